>>> sv/psniff_pkg.sv
// Package for the plist sidecar sniffer: tag patterns, flag slots, verdict and register codes.
package psniff_pkg;

	// Tags packed so that the final character sits in the low byte,
	// which lines up with the current byte of the match window.
	localparam logic [39:0] TAG_DECL   = "<?xml";
	localparam logic [47:0] TAG_ROOT   = "<plist";
	localparam logic [63:0] TAG_PCLOSE = "</plist>";
	localparam logic [47:0] TAG_DOPEN  = "<dict>";
	localparam logic [55:0] TAG_DCLOSE = "</dict>";
	localparam logic [39:0] TAG_KEY    = "<key>";

	// Bytes held ahead of the current one
	localparam int unsigned HIST_DEPTH = 7;
	localparam int unsigned WIN_BITS   = 8 * (HIST_DEPTH + 1);

	localparam int unsigned CFG_BITS   = 16;
	localparam int unsigned CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MIN_LENGTH  = 2'd0,
		REG_DECL_WINDOW = 2'd1,
		REG_ROOT_WINDOW = 2'd2
	} reg_idx_t;

	localparam logic [CFG_BITS-1:0] MIN_LENGTH_RST  = 16'd64;
	localparam logic [CFG_BITS-1:0] DECL_WINDOW_RST = 16'd16;
	localparam logic [CFG_BITS-1:0] ROOT_WINDOW_RST = 16'd512;

	typedef enum logic [1:0] {
		VERDICT_VALID   = 2'd0,
		VERDICT_INVALID = 2'd1,
		VERDICT_WRONG   = 2'd2
	} verdict_t;

	// One hit per tag, ending at the current byte
	typedef struct packed {
		logic key;
		logic dclose;
		logic dopen;
		logic pclose;
		logic root;
		logic decl;
	} hits_t;

endpackage

>>> sv/psniff_match.sv
// Tag comparators over the eight-byte match window.
module psniff_match (
	input  logic [psniff_pkg::WIN_BITS-1:0] win,
	output psniff_pkg::hits_t               hits
);

	// win[7:0] is the current byte, older bytes sit above it
	always_comb begin
		hits.decl   = (win[39:0] == psniff_pkg::TAG_DECL);
		hits.root   = (win[47:0] == psniff_pkg::TAG_ROOT);
		hits.pclose = (win[63:0] == psniff_pkg::TAG_PCLOSE);
		hits.dopen  = (win[47:0] == psniff_pkg::TAG_DOPEN);
		hits.dclose = (win[55:0] == psniff_pkg::TAG_DCLOSE);
		hits.key    = (win[39:0] == psniff_pkg::TAG_KEY);
	end

endmodule

>>> sv/plist_sidecar_sniffer.sv
// Top level of the plist sidecar sniffer: byte window, counters, found flags and verdict.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+--------------------------
//  byte in   | byte_valid / byte_stall     | byte_in[7:0], last
//  verdict   | verdict_valid / verdict_stall | verdict[1:0]
//  config    | cfg_we (no wait)            | cfg_index[1:0], cfg_data[15:0]
//
// One byte per cycle sustained while byte_stall is low. A byte is registered at
// the input stage, then matched, counted and flagged; the verdict for a final
// byte is loaded into the output register as that byte leaves the input stage.
// Reset (arst_n low) sets the registers to 64/16/512 and clears file state.
// byte_stall rises only when a final byte in the input stage waits on a full,
// stalled output register; a staged byte that gives no verdict never waits.
module plist_sidecar_sniffer #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// byte channel
	input  logic                                   byte_valid,
	output logic                                   byte_stall,
	input  logic [7:0]                             byte_in,
	input  logic                                   last,
	// verdict channel
	output logic                                   verdict_valid,
	input  logic                                   verdict_stall,
	output logic [1:0]                             verdict,
	// configuration writes
	input  logic                                   cfg_we,
	input  logic [psniff_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [psniff_pkg::CFG_BITS-1:0]        cfg_data
);

	localparam int unsigned HD = psniff_pkg::HIST_DEPTH;

	// configuration registers
	logic [psniff_pkg::CFG_BITS-1:0] min_length_q;
	logic [psniff_pkg::CFG_BITS-1:0] decl_window_q;
	logic [psniff_pkg::CFG_BITS-1:0] root_window_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// per-file state
	logic [8*HD-1:0]       recent_q;   // recent_q[7:0] is the newest byte
	logic [COUNT_BITS-1:0] count_q;
	psniff_pkg::hits_t     flags_q;

	// output register
	logic                  out_valid_q;
	psniff_pkg::verdict_t  verdict_q;

	logic                          adv;
	logic                          out_free;
	logic [psniff_pkg::WIN_BITS-1:0] win;
	psniff_pkg::hits_t             hits;
	psniff_pkg::hits_t             flags_next;
	logic [COUNT_BITS-1:0]         count_next;
	psniff_pkg::verdict_t          verdict_next;

	// --- configuration -----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q  <= psniff_pkg::MIN_LENGTH_RST;
			decl_window_q <= psniff_pkg::DECL_WINDOW_RST;
			root_window_q <= psniff_pkg::ROOT_WINDOW_RST;
		end else if (cfg_we) begin
			case (psniff_pkg::reg_idx_t'(cfg_index))
				psniff_pkg::REG_MIN_LENGTH:  min_length_q  <= cfg_data;
				psniff_pkg::REG_DECL_WINDOW: decl_window_q <= cfg_data;
				psniff_pkg::REG_ROOT_WINDOW: root_window_q <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// --- handshake ---------------------------------------------------------
	// The output register is free if empty or being drained this cycle.
	assign out_free   = !out_valid_q || !verdict_stall;
	// The staged byte moves on unless it needs the output register and cannot have it.
	assign adv        = valid_s1 && (!last_s1 || out_free);
	assign byte_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= byte_in;
			last_s1 <= last;
		end
	end

	// --- match, count, flag ------------------------------------------------
	assign win = {recent_q, byte_s1};

	psniff_match u_match (
		.win  (win),
		.hits (hits)
	);

	// Count saturates at all ones.
	assign count_next = (&count_q) ? count_q : count_q + COUNT_BITS'(1);

	always_comb begin
		flags_next        = flags_q;
		flags_next.decl   = flags_q.decl
			| (hits.decl && (count_next <= COUNT_BITS'(decl_window_q)));
		flags_next.root   = flags_q.root
			| (hits.root && (count_next <= COUNT_BITS'(root_window_q)));
		flags_next.pclose = flags_q.pclose | hits.pclose;
		flags_next.dopen  = flags_q.dopen  | hits.dopen;
		flags_next.dclose = flags_q.dclose | hits.dclose;
		flags_next.key    = flags_q.key    | hits.key;
	end

	// Priority: too short, then early markers, then structure.
	always_comb begin
		if (count_next < COUNT_BITS'(min_length_q)) begin
			verdict_next = psniff_pkg::VERDICT_WRONG;
		end else if (!flags_next.decl || !flags_next.root) begin
			verdict_next = psniff_pkg::VERDICT_WRONG;
		end else if (!flags_next.pclose || !flags_next.dopen
				|| !flags_next.dclose || !flags_next.key) begin
			verdict_next = psniff_pkg::VERDICT_INVALID;
		end else begin
			verdict_next = psniff_pkg::VERDICT_VALID;
		end
	end

	// File state; cleared after the final byte so the next file starts fresh.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			count_q  <= '0;
			flags_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				recent_q <= '0;
				count_q  <= '0;
				flags_q  <= '0;
			end else begin
				recent_q <= {recent_q[8*(HD-1)-1:0], byte_s1};
				count_q  <= count_next;
				flags_q  <= flags_next;
			end
		end
	end

	// --- output register ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			verdict_q <= verdict_next;
		end
	end

	assign verdict_valid = out_valid_q;
	assign verdict       = verdict_q;

`ifndef SYNTHESIS
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict != 2'd3))
		else $error("verdict carries an unused code");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (count_q == '0 && flags_q == '0 && recent_q == '0))
		else $error("file state not cleared after final byte");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !last_s1) |=> (count_q != '0))
		else $error("byte count did not advance");

	a_stall_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && last_s1 && out_valid_q && verdict_stall))
		else $error("input stalled without a blocked verdict");

	a_verdict_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> verdict_valid)
		else $error("final byte gave no verdict");
`endif

endmodule
